// ===== src/burst_period_averager_unit_macros.svh =====
// assertion macros for the burst period averager
// used by burst_period_averager_unit.sv, expects aclk and aresetn in scope
`ifndef BURST_PERIOD_AVERAGER_UNIT_MACROS_SVH
`define BURST_PERIOD_AVERAGER_UNIT_MACROS_SVH

// same-cycle implication
`define BPA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BPA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/bpa_pkg.sv =====
// shared types and constants of the burst period averager
// no dependencies; used by bpa_div, burst_period_averager_unit and the testbench
`default_nettype none

package bpa_pkg;

    localparam int SAMPLE_W = 16;
    localparam int AVG_W    = 40;
    localparam int BURST_W  = 6;
    localparam int CFG_AW   = 4;
    localparam int CFG_DW   = 32;

    localparam logic [AVG_W-1:0]    AVG_MAX       = {AVG_W{1'b1}};
    localparam logic [SAMPLE_W-1:0] THR_LO_RST    = 16'hC000;
    localparam logic [SAMPLE_W-1:0] THR_HI_RST    = 16'h4000;
    localparam logic [BURST_W-1:0]  BURSTS_RST    = 6'd20;
    localparam logic [31:0]         MAX_SMP_RST   = 32'd4000000;
    localparam logic signed [BURST_W:0] BURST_CNT_RST = -7'sd1;

    typedef enum logic [1:0] {
        REG_THR_LO  = 2'd0,
        REG_THR_HI  = 2'd1,
        REG_BURSTS  = 2'd2,
        REG_MAX_SMP = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_DIV,
        ST_PUT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

// ===== src/bpa_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle
// depends on bpa_pkg for the status struct
`default_nettype none

module bpa_div import bpa_pkg::*; #(
    parameter int DW = 40,
    parameter int VW = 6
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [VW-1:0] divisor,
    output logic      [DW-1:0] quotient,
    output div_stat_t          stat
);

    localparam int CNTW = $clog2(DW + 1);

    logic [VW-1:0]   rem_reg, rem_next;
    logic [DW-1:0]   quo_reg, quo_next;
    logic [VW-1:0]   dvs_reg, dvs_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [VW:0]     shifted;
    logic [VW:0]     diff;
    logic            take;

    assign shifted = {rem_reg, quo_reg[DW-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign take    = shifted >= {1'b0, dvs_reg};

    always_comb begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        if (start) begin
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
            cnt_next = CNTW'(DW);
        end else if (cnt_reg != '0) begin
            // remainder stays below the divisor, so it fits in VW bits
            rem_next = take ? diff[VW-1:0] : shifted[VW-1:0];
            quo_next = {quo_reg[DW-2:0], take};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = cnt_reg != '0;
    assign stat.done = cnt_reg == CNTW'(1);

endmodule

`default_nettype wire

// ===== src/burst_period_averager_unit.sv =====
// burst period averager: accepts samples without stalling while a measurement runs
// a run with a complete burst ends in the bit-serial divider before the result is staged in
// the output register, with s_tready low meanwhile; without a complete burst the result is
// staged without the divider; a result still waiting on m_tready holds the input off longer
// synchronous active-low reset clears the run state and loads register reset values
`default_nettype none
`include "burst_period_averager_unit_macros.svh"

module burst_period_averager_unit import bpa_pkg::*; #(
    parameter int COUNT_WIDTH = 32,
    parameter int FRAC_BITS   = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // input stream
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [15:0]       s_tdata,   // [15:0] sample
    input  wire logic              s_tuser,   // [0] first
    // result stream
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [47:0]       m_tdata,   // [39:0] average_steps, [45:40] bursts_counted
    output logic                   m_tuser,   // [0] valid_res
    // register port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [CFG_DW-1:0] pwdata,
    output logic      [CFG_DW-1:0] prdata,
    output logic                   pready
);

    localparam int QW = COUNT_WIDTH + FRAC_BITS;
    localparam int LW = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    // configuration registers
    logic [SAMPLE_W-1:0] thr_lo_reg, thr_hi_reg;
    logic [BURST_W-1:0]  bursts_reg;
    logic [31:0]         max_smp_reg;
    logic                cfg_wr;
    reg_idx_t            cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_lo_reg  <= THR_LO_RST;
            thr_hi_reg  <= THR_HI_RST;
            bursts_reg  <= BURSTS_RST;
            max_smp_reg <= MAX_SMP_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_THR_LO:  thr_lo_reg  <= pwdata[SAMPLE_W-1:0];
                REG_THR_HI:  thr_hi_reg  <= pwdata[SAMPLE_W-1:0];
                REG_BURSTS:  bursts_reg  <= pwdata[BURST_W-1:0];
                REG_MAX_SMP: max_smp_reg <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_THR_LO:  prdata = {{(CFG_DW-SAMPLE_W){1'b0}}, thr_lo_reg};
            REG_THR_HI:  prdata = {{(CFG_DW-SAMPLE_W){1'b0}}, thr_hi_reg};
            REG_BURSTS:  prdata = {{(CFG_DW-BURST_W){1'b0}}, bursts_reg};
            REG_MAX_SMP: prdata = max_smp_reg;
            default:     prdata = '0;
        endcase
    end

    // measurement state
    state_t                    state_reg, state_next;
    logic                      up_reg, up_next;
    logic signed [BURST_W:0]   bc_reg, bc_next;
    logic [COUNT_WIDTH-1:0]    steps_reg, steps_next;
    logic [COUNT_WIDTH-1:0]    total_reg, total_next;
    logic [COUNT_WIDTH-1:0]    smp_reg, smp_next;
    logic                      run_reg, run_next;
    logic                      rvalid_reg, rvalid_next;
    logic [BURST_W-1:0]        rcnt_reg, rcnt_next;

    // output register
    logic                      mvalid_reg, mvalid_next;
    logic [AVG_W-1:0]          mavg_reg, mavg_next;
    logic [BURST_W-1:0]        mcnt_reg, mcnt_next;
    logic                      mres_reg, mres_next;

    logic                      accept;
    logic                      finish;
    logic                      load_out;
    logic                      div_start;
    logic signed [SAMPLE_W-1:0] smp_val;
    logic                      above_hi, below_lo;
    logic [COUNT_WIDTH:0]      smp_inc, tot_sum, stp_inc;
    logic [COUNT_WIDTH-1:0]    steps_mid;
    logic                      run_valid;
    logic [QW-1:0]             dividend;
    logic [QW-1:0]             quotient;
    logic                      q_sat;
    div_stat_t                 div_stat;

    assign accept   = s_tvalid && s_tready;
    assign smp_val  = $signed(s_tdata);
    assign above_hi = smp_val > $signed(thr_hi_reg);
    assign below_lo = smp_val < $signed(thr_lo_reg);
    assign smp_inc  = {1'b0, smp_reg} + 1'b1;

    // per-sample update and end-of-run test
    always_comb begin
        up_next    = up_reg;
        bc_next    = bc_reg;
        steps_next = steps_reg;
        total_next = total_reg;
        smp_next   = smp_reg;
        run_next   = run_reg;
        finish     = 1'b0;
        tot_sum    = {1'b0, total_reg} + {1'b0, steps_reg};
        steps_mid  = steps_reg;
        stp_inc    = '0;
        if (accept) begin
            if (s_tuser) begin
                up_next    = above_hi;
                bc_next    = BURST_CNT_RST;
                steps_next = '0;
                total_next = '0;
                smp_next   = '0;
                run_next   = 1'b1;
                finish     = max_smp_reg == '0;
            end else if (run_reg) begin
                smp_next = smp_inc[COUNT_WIDTH] ? CNT_MAX : smp_inc[COUNT_WIDTH-1:0];
                if (!up_reg && above_hi) begin
                    up_next    = 1'b1;
                    bc_next    = bc_reg + (BURST_W+1)'(1);
                    total_next = tot_sum[COUNT_WIDTH] ? CNT_MAX : tot_sum[COUNT_WIDTH-1:0];
                    steps_mid  = '0;
                end else if (up_reg && below_lo) begin
                    up_next = 1'b0;
                end
                stp_inc    = {1'b0, steps_mid} + 1'b1;
                steps_next = stp_inc[COUNT_WIDTH] ? CNT_MAX : stp_inc[COUNT_WIDTH-1:0];
                finish     = (bc_next >= $signed({1'b0, bursts_reg}))
                          || (LW'(smp_next) >= LW'(max_smp_reg));
            end
            if (finish) begin
                run_next = 1'b0;
            end
        end
    end

    assign run_valid = bc_next > 0;
    assign dividend  = QW'(total_next) << FRAC_BITS;

    // sequencer: next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_RUN: begin
                if (finish) begin
                    state_next = run_valid ? ST_DIV : ST_PUT;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT: begin
                if (!mvalid_reg || m_tready) begin
                    state_next = ST_RUN;
                end
            end
            default: state_next = ST_RUN;
        endcase
    end

    // sequencer: outputs
    always_comb begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            ST_RUN: begin
                s_tready  = 1'b1;
                div_start = finish && run_valid;
            end
            ST_DIV: ;
            ST_PUT: load_out = !mvalid_reg || m_tready;
            default: ;
        endcase
    end

    always_comb begin
        rvalid_next = rvalid_reg;
        rcnt_next   = rcnt_reg;
        if (finish) begin
            rvalid_next = run_valid;
            rcnt_next   = run_valid ? bc_next[BURST_W-1:0] : '0;
        end
    end

    bpa_div #(
        .DW (QW),
        .VW (BURST_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (bc_next[BURST_W-1:0]),
        .quotient (quotient),
        .stat     (div_stat)
    );

    assign q_sat = (QW > AVG_W) && (quotient > QW'(AVG_MAX));

    always_comb begin
        mvalid_next = mvalid_reg;
        mavg_next   = mavg_reg;
        mcnt_next   = mcnt_reg;
        mres_next   = mres_reg;
        if (m_tvalid && m_tready) begin
            mvalid_next = 1'b0;
        end
        if (load_out) begin
            mvalid_next = 1'b1;
            mres_next   = rvalid_reg;
            mcnt_next   = rcnt_reg;
            if (!rvalid_reg) begin
                mavg_next = '0;
            end else begin
                mavg_next = q_sat ? AVG_MAX : AVG_W'(quotient);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_RUN;
            up_reg     <= 1'b0;
            bc_reg     <= BURST_CNT_RST;
            steps_reg  <= '0;
            total_reg  <= '0;
            smp_reg    <= '0;
            run_reg    <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            up_reg     <= up_next;
            bc_reg     <= bc_next;
            steps_reg  <= steps_next;
            total_reg  <= total_next;
            smp_reg    <= smp_next;
            run_reg    <= run_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rvalid_reg <= rvalid_next;
        rcnt_reg   <= rcnt_next;
        mavg_reg   <= mavg_next;
        mcnt_reg   <= mcnt_next;
        mres_reg   <= mres_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {{(48-AVG_W-BURST_W){1'b0}}, mcnt_reg, mavg_reg};
    assign m_tuser  = mres_reg;

    `BPA_ASSERT_IMP(a_no_input_while_dividing, div_stat.busy, !s_tready,
        "sample taken while divider busy")
    `BPA_ASSERT_IMP(a_invalid_result_zero, m_tvalid && !m_tuser,
        m_tdata == '0, "invalid result carries nonzero data")
    `BPA_ASSERT_IMP(a_valid_result_has_bursts, m_tvalid && m_tuser,
        m_tdata[45:40] != '0, "valid result with zero bursts")
    `BPA_ASSERT_NXT(a_div_leads_to_put, state_reg == ST_DIV && div_stat.done,
        state_reg == ST_PUT, "divider finished but result not staged")

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// testbench for burst_period_averager_unit: sample stream in, burst period averages out
// depends on bpa_pkg and the unit itself; a behavioral predictor checks every result transfer

module testbench import bpa_pkg::*;;

    localparam int COUNT_W = 32;
    localparam int FRAC    = 8;
    // settle time before register writes, sized from the divider pass plus sequencing
    localparam int SETTLE_CYCLES = 2 * (COUNT_W + FRAC + 2);

    typedef struct {
        logic [AVG_W-1:0]   avg;
        logic [BURST_W-1:0] bursts;
        logic               ok;
    } burst_avg_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    wire               s_tready;
    logic [15:0]       s_tdata  = '0;
    logic              s_tuser  = 1'b0;
    wire               m_tvalid;
    logic              m_tready = 1'b0;
    wire  [47:0]       m_tdata;
    wire               m_tuser;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [CFG_AW-1:0] paddr    = '0;
    logic [CFG_DW-1:0] pwdata   = '0;
    wire  [CFG_DW-1:0] prdata;
    wire               pready;

    // predictor copy of the registers
    logic signed [15:0]  thr_lo      = THR_LO_RST;
    logic signed [15:0]  thr_hi      = THR_HI_RST;
    logic [BURST_W-1:0]  burst_goal  = BURSTS_RST;
    logic [31:0]         sample_limit = MAX_SMP_RST;

    // predictor copy of the measurement state
    logic        above_high     = 1'b0;
    int          burst_idx      = -1;
    logic [31:0] steps_run      = '0;
    logic [31:0] steps_total    = '0;
    logic [31:0] samples_in_run = '0;
    logic        in_run         = 1'b0;

    burst_avg_t expected_avgs[$];
    int   samples_used   = 0;
    int   mismatch_count = 0;
    int   rx_hold_cycles = 0;
    logic tx_idle_en     = 1'b1;
    logic rx_idle_en     = 1'b1;

    burst_period_averager_unit #(
        .COUNT_WIDTH(COUNT_W),
        .FRAC_BITS  (FRAC)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    function automatic logic [31:0] sat_add32(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic run_complete();
        return (burst_idx >= int'(burst_goal)) || (samples_in_run >= sample_limit);
    endfunction

    function automatic void predict_sample(logic [15:0] raw, logic first);
        logic signed [15:0] v;
        logic               ended;
        logic [63:0]        quot;
        burst_avg_t         res;
        v = raw;
        ended = 1'b0;
        if (first) begin
            above_high     = v > thr_hi;
            burst_idx      = -1;
            steps_run      = '0;
            steps_total    = '0;
            samples_in_run = '0;
            in_run         = 1'b1;
            samples_used++;
            ended = run_complete();
        end else if (in_run) begin
            samples_used++;
            samples_in_run = sat_add32(samples_in_run, 32'd1);
            if (!above_high && v > thr_hi) begin
                above_high  = 1'b1;
                burst_idx++;
                steps_total = sat_add32(steps_total, steps_run);
                steps_run   = '0;
            end else if (above_high && v < thr_lo) begin
                above_high = 1'b0;
            end
            steps_run = sat_add32(steps_run, 32'd1);
            ended = run_complete();
        end
        if (ended) begin
            in_run = 1'b0;
            if (burst_idx <= 0) begin
                res = '{avg: '0, bursts: '0, ok: 1'b0};
            end else begin
                quot = ({32'b0, steps_total} << FRAC) / 64'(burst_idx);
                res.avg    = (quot > 64'(AVG_MAX)) ? AVG_MAX : quot[AVG_W-1:0];
                res.bursts = BURST_W'(burst_idx);
                res.ok     = 1'b1;
            end
            expected_avgs.insert(expected_avgs.size(), res);
        end
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'({idx, 2'b00});
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_THR_LO:  thr_lo       = val[15:0];
            REG_THR_HI:  thr_hi       = val[15:0];
            REG_BURSTS:  burst_goal   = val[BURST_W-1:0];
            REG_MAX_SMP: sample_limit = val;
            default: ;
        endcase
        // leave the bus idle before the next transfer
        @(posedge aclk);
    endtask

    task automatic send_sample(logic [15:0] smp, logic first);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tuser  <= first;
        do @(posedge aclk); while (!s_tready);
        predict_sample(smp, first);
    endtask

    // stop offering, wait for every pending result, then let the divider settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_avgs.size() > 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(int lo, int hi, int goal, logic [31:0] limit);
        wait_drained();
        write_reg(REG_THR_LO, 32'(lo));
        write_reg(REG_THR_HI, 32'(hi));
        write_reg(REG_BURSTS, 32'(goal));
        write_reg(REG_MAX_SMP, limit);
    endtask

    function automatic logic [15:0] rand_above();
        int h;
        h = thr_hi;
        if (h >= 32767) return 16'($urandom);
        return 16'(h + 1 + int'($urandom_range(0, 32766 - h)));
    endfunction

    function automatic logic [15:0] rand_below();
        int l;
        l = thr_lo;
        if (l <= -32768) return 16'($urandom);
        return 16'(-32768 + int'($urandom_range(0, l + 32767)));
    endfunction

    function automatic logic [15:0] rand_between();
        int l, h;
        l = thr_lo;
        h = thr_hi;
        if (l > h) return 16'($urandom);
        return 16'(l + int'($urandom_range(0, h - l)));
    endfunction

    // one measurement: a first-marked sample, then n rise/fall cycles with filler
    task automatic run_burst_train(int n);
        send_sample(16'($urandom), 1'b1);
        repeat (n) begin
            repeat ($urandom_range(0, 2)) send_sample(rand_between(), 1'b0);
            repeat ($urandom_range(1, 3)) send_sample(rand_above(), 1'b0);
            repeat ($urandom_range(0, 2)) send_sample(rand_between(), 1'b0);
            repeat ($urandom_range(1, 2)) send_sample(rand_below(), 1'b0);
        end
    endtask

    task automatic test_reset_defaults();
        run_burst_train(21);
    endtask

    task automatic test_directed_cases();
        set_config(-100, 100, 2, 32'd1000);
        // not running yet: ignored
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b1);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        // restart mid-run, then thresholds hit exactly and just past
        send_sample(16'h8000, 1'b1);
        send_sample(16'(101), 1'b0);
        send_sample(16'(100), 1'b0);
        send_sample(16'(-100), 1'b0);
        send_sample(16'(-101), 1'b0);
        send_sample(16'(200), 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        // zero burst target ends at the first crossing
        set_config(-100, 100, 0, 32'd1000);
        send_sample(16'(0), 1'b1);
        send_sample(16'h7FFF, 1'b0);
        // zero sample limit ends on the first-marked sample
        set_config(-100, 100, 0, 32'd0);
        send_sample(16'h7FFF, 1'b1);
        // sample limit reached with only the opening crossing
        set_config(-100, 100, 2, 32'd3);
        send_sample(16'(-5), 1'b1);
        send_sample(16'(500), 1'b0);
        send_sample(16'(-500), 1'b0);
        send_sample(16'(0), 1'b0);
    endtask

    task automatic test_register_extremes();
        // no sample can cross, so a run can end only on the limit
        set_config(-32768, 32767, 63, 32'd40);
        repeat (2) run_burst_train(10);
        // inverted thresholds
        set_config(32767, -32768, 1, 32'hFFFF_FFFF);
        repeat (3) run_burst_train(3);
        // largest burst target
        set_config(-1000, 1000, 63, 32'hFFFF_FFFF);
        run_burst_train(64);
        set_config(-1000, 1000, 63, 32'd1);
        repeat (3) run_burst_train(1);
    endtask

    task automatic test_back_to_back();
        set_config(-2000, 2000, 3, 32'd60);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (6) run_burst_train(4);
        wait_drained();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    task automatic test_output_stall();
        set_config(-50, 50, 1, 32'd6);
        tx_idle_en     = 1'b0;
        rx_hold_cycles = 400;
        repeat (8) run_burst_train(2);
        wait_drained();
        tx_idle_en = 1'b1;
    endtask

    task automatic randomize_config();
        int lo, hi, swap, goal;
        logic [31:0] limit;
        lo = int'($urandom_range(0, 65535)) - 32768;
        hi = int'($urandom_range(0, 65535)) - 32768;
        if ($urandom_range(0, 7) != 0 && lo > hi) begin
            swap = lo;
            lo   = hi;
            hi   = swap;
        end
        case ($urandom_range(0, 15))
            0:       goal = 0;
            1:       goal = $urandom_range(13, 63);
            default: goal = $urandom_range(1, 12);
        endcase
        case ($urandom_range(0, 7))
            0:       limit = $urandom;
            1:       limit = $urandom_range(0, 3);
            default: limit = $urandom_range(8, 150);
        endcase
        set_config(lo, hi, goal, limit);
        tx_idle_en = $urandom_range(0, 3) != 0;
        rx_idle_en = $urandom_range(0, 3) != 0;
    endtask

    task automatic test_random_runs(int n_items);
        int stop_at, phase_end;
        stop_at = samples_used + n_items;
        while (samples_used < stop_at) begin
            randomize_config();
            phase_end = samples_used + 60;
            // open each phase with a fresh run so no result comes from a run that spans a register write
            run_burst_train($urandom_range(0, burst_goal + 1));
            while (samples_used < phase_end) begin
                if ($urandom_range(0, 4) != 0) begin
                    run_burst_train($urandom_range(0, burst_goal + 1));
                end else begin
                    repeat ($urandom_range(1, 8))
                        send_sample(16'($urandom), $urandom_range(0, 15) == 0);
                end
            end
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // result sink: draws a stall per transfer and checks against the oldest prediction
    initial begin : result_sink
        burst_avg_t want;
        int         stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (rx_hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge aclk);
                rx_hold_cycles = 0;
            end
            stall = rx_idle_en ? $urandom_range(0, 15) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            if (expected_avgs.size() == 0) begin
                report_mismatch("unexpected result", m_tdata, 0);
            end else begin
                want = expected_avgs.pop_front();
                if (m_tdata[39:0] !== want.avg)
                    report_mismatch("average_steps", m_tdata[39:0], want.avg);
                if (m_tdata[45:40] !== want.bursts)
                    report_mismatch("bursts_counted", m_tdata[45:40], want.bursts);
                if (m_tuser !== want.ok)
                    report_mismatch("valid_res", m_tuser, want.ok);
            end
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_directed_cases();
        test_register_extremes();
        test_back_to_back();
        test_output_stall();
        test_random_runs(200);
        wait_drained();
        if (mismatch_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/bpa_pkg.sv
src/bpa_div.sv
src/burst_period_averager_unit.sv
verif/testbench.sv
